FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define IFSCG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define IFSCG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ifscg_pkg.sv
// Package: constants, types and address helper for the IFS point engine
`default_nettype none

package ifscg_pkg;

  localparam int NUM_MAPS      = 32;
  localparam int FRAC_BITS     = 16;
  localparam int COEFS_PER_MAP = 13;
  localparam int PROB_SLOT     = 12;
  localparam int OFFSET_SLOT   = 9;
  localparam int RAND_SPAN     = 32767;
  localparam int WORD_W        = 32;
  localparam int PROD_W        = 2 * WORD_W;
  localparam int SLOT_W        = 4;
  localparam int MAP_IN_W      = 5;
  localparam int RAND_W        = 15;
  localparam int TABLE_DEPTH   = NUM_MAPS * COEFS_PER_MAP;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int MAP_W         = $clog2(NUM_MAPS);
  localparam int RAND_SCALE    = (1 << FRAC_BITS) / RAND_SPAN;
  localparam int LAST_ROW      = 2;
  localparam int OFFSET_COL    = 3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [MAP_W-1:0]  map_t;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P0_RD,
    ST_P0_LD,
    ST_WTEST,
    ST_WADD,
    ST_WPEEK,
    ST_M_RD,
    ST_M_MUL,
    ST_M_ACC,
    ST_DONE
  } state_t;

  // controls from the sequencer to the datapath
  typedef struct packed {
    logic       r_load;
    logic       sum_init;
    logic       sum_add;
    logic       prod_load;
    logic       acc_add;
    logic       row_end;
    logic       restart;
    logic [1:0] row;
    logic [1:0] col;
  } dp_ctl_t;

  // status from the datapath back to the sequencer
  typedef struct packed {
    logic sum_below;
    logic data_zero;
  } dp_sts_t;

  // result register controls
  typedef struct packed {
    logic                load;
    logic                zero_point;
    logic [MAP_IN_W-1:0] chosen;
  } out_ctl_t;

  function automatic addr_t coef_addr(input addr_t map, input logic [SLOT_W-1:0] slot);
    addr_t base;
    base = addr_t'(map * addr_t'(COEFS_PER_MAP));
    return base + addr_t'(slot);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ifscg_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module ifscg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 416
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ifscg_dpath.sv
// Datapath: walk sum, shared multiplier, accumulator and point registers
`default_nettype none

module ifscg_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic        [ifscg_pkg::RAND_W-1:0] in_random_value,
  input  wire ifscg_pkg::dp_ctl_t                  ctl,
  input  wire logic        [ifscg_pkg::WORD_W-1:0] rd_data,
  output ifscg_pkg::dp_sts_t                       sts,
  output logic signed      [ifscg_pkg::WORD_W-1:0] cur_x,
  output logic signed      [ifscg_pkg::WORD_W-1:0] cur_y,
  output logic signed      [ifscg_pkg::WORD_W-1:0] cur_z
);

  logic signed [ifscg_pkg::WORD_W-1:0] r_r, sum_r, acc_r, nx_r, ny_r;
  logic signed [ifscg_pkg::WORD_W-1:0] cur_x_r, cur_y_r, cur_z_r;
  logic signed [ifscg_pkg::PROD_W-1:0] prod_r;
  logic signed [ifscg_pkg::WORD_W-1:0] operand, coef, row_val, prod_fx;

  assign coef    = $signed(rd_data);
  assign row_val = acc_r + coef;
  // arithmetic shift right by the fraction width, low word kept
  assign prod_fx = prod_r[ifscg_pkg::FRAC_BITS + ifscg_pkg::WORD_W - 1 : ifscg_pkg::FRAC_BITS];

  always_comb begin
    case (ctl.col)
      2'd0:    operand = cur_x_r;
      2'd1:    operand = cur_y_r;
      default: operand = cur_z_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.r_load) begin
      r_r <= ifscg_pkg::WORD_W'(in_random_value) * ifscg_pkg::WORD_W'(ifscg_pkg::RAND_SCALE);
    end
    if (ctl.sum_init) begin
      sum_r <= coef;
    end else if (ctl.sum_add) begin
      sum_r <= sum_r + coef;
    end
    if (ctl.prod_load) begin
      prod_r <= coef * operand;
    end
    if (ctl.r_load || ctl.row_end) begin
      acc_r <= '0;
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + prod_fx;
    end
    if (ctl.row_end && ctl.row == 2'd0) begin
      nx_r <= row_val;
    end
    if (ctl.row_end && ctl.row == 2'd1) begin
      ny_r <= row_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      cur_z_r <= '0;
    end else if (ctl.restart) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      cur_z_r <= '0;
    end else if (ctl.row_end && ctl.row == 2'(ifscg_pkg::LAST_ROW)) begin
      // all three rows read the old point, so commit together
      cur_x_r <= nx_r;
      cur_y_r <= ny_r;
      cur_z_r <= row_val;
    end
  end

  assign sts.sum_below = (sum_r < r_r);
  assign sts.data_zero = (rd_data == '0);

  assign cur_x = cur_x_r;
  assign cur_y = cur_y_r;
  assign cur_z = cur_z_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ifscg_ctrl.sv
// Sequencer: table clear, map selection walk and affine evaluation order
`default_nettype none

module ifscg_ctrl (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [1:0]                     in_op,
  input  wire logic        [ifscg_pkg::MAP_IN_W-1:0] in_map_index,
  input  wire logic        [ifscg_pkg::SLOT_W-1:0]   in_coef_slot,
  input  wire logic signed [ifscg_pkg::WORD_W-1:0]   in_coef_value,
  input  wire logic                                  out_free,
  input  wire ifscg_pkg::dp_sts_t                    sts,
  output ifscg_pkg::dp_ctl_t                         ctl,
  output ifscg_pkg::out_ctl_t                        oc,
  output logic                                       ram_we,
  output ifscg_pkg::addr_t                           ram_waddr,
  output logic             [ifscg_pkg::WORD_W-1:0]   ram_wdata,
  output ifscg_pkg::addr_t                           ram_raddr
);

  ifscg_pkg::state_t state_r, state_nxt;
  ifscg_pkg::map_t   k_r, k_nxt;
  ifscg_pkg::addr_t  clr_r, clr_nxt;
  logic [1:0]        row_r, row_nxt, col_r, col_nxt;
  logic              accept, load_ok, clr_last, walk_go, walk_end;
  logic [ifscg_pkg::SLOT_W-1:0] mat_slot;

  assign accept   = in_valid && !in_stall;
  assign load_ok  = (in_coef_slot < ifscg_pkg::SLOT_W'(ifscg_pkg::COEFS_PER_MAP))
                 && (32'(in_map_index) < 32'(ifscg_pkg::NUM_MAPS));
  assign clr_last = (clr_r == ifscg_pkg::addr_t'(ifscg_pkg::TABLE_DEPTH - 1));
  assign walk_go  = sts.sum_below && (k_r != ifscg_pkg::map_t'(ifscg_pkg::NUM_MAPS - 1));
  // next advance lands on the last map
  assign walk_end = (k_r == ifscg_pkg::map_t'(ifscg_pkg::NUM_MAPS - 2));
  assign mat_slot = (col_r == 2'(ifscg_pkg::OFFSET_COL))
                  ? ifscg_pkg::SLOT_W'(ifscg_pkg::OFFSET_SLOT) + ifscg_pkg::SLOT_W'(row_r)
                  : ifscg_pkg::SLOT_W'(row_r) * ifscg_pkg::SLOT_W'(3) + ifscg_pkg::SLOT_W'(col_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ifscg_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ifscg_pkg::ST_IDLE;
        end
      end
      ifscg_pkg::ST_IDLE: begin
        if (accept && in_op == ifscg_pkg::OP_STEP) begin
          state_nxt = ifscg_pkg::ST_P0_RD;
        end
      end
      ifscg_pkg::ST_P0_RD: state_nxt = ifscg_pkg::ST_P0_LD;
      ifscg_pkg::ST_P0_LD: state_nxt = ifscg_pkg::ST_WTEST;
      ifscg_pkg::ST_WTEST: begin
        state_nxt = walk_go ? ifscg_pkg::ST_WADD : ifscg_pkg::ST_M_RD;
      end
      ifscg_pkg::ST_WADD: begin
        state_nxt = walk_end ? ifscg_pkg::ST_M_RD : ifscg_pkg::ST_WPEEK;
      end
      ifscg_pkg::ST_WPEEK: begin
        state_nxt = sts.data_zero ? ifscg_pkg::ST_M_RD : ifscg_pkg::ST_WTEST;
      end
      ifscg_pkg::ST_M_RD: state_nxt = ifscg_pkg::ST_M_MUL;
      ifscg_pkg::ST_M_MUL: begin
        if (col_r != 2'(ifscg_pkg::OFFSET_COL)) begin
          state_nxt = ifscg_pkg::ST_M_ACC;
        end else if (row_r == 2'(ifscg_pkg::LAST_ROW)) begin
          state_nxt = ifscg_pkg::ST_DONE;
        end else begin
          state_nxt = ifscg_pkg::ST_M_RD;
        end
      end
      ifscg_pkg::ST_M_ACC: state_nxt = ifscg_pkg::ST_M_RD;
      ifscg_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ifscg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ifscg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ifscg_pkg::ST_IDLE) || !out_free;
    ctl       = '0;
    ctl.row   = row_r;
    ctl.col   = col_r;
    oc        = '0;
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    ram_raddr = '0;
    k_nxt     = k_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    clr_nxt   = clr_r;
    case (state_r)
      ifscg_pkg::ST_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + ifscg_pkg::addr_t'(1);
      end
      ifscg_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op)
            ifscg_pkg::OP_LOAD: begin
              ram_we    = load_ok;
              ram_waddr = ifscg_pkg::coef_addr(ifscg_pkg::addr_t'(in_map_index), in_coef_slot);
              ram_wdata = in_coef_value;
              oc.load   = 1'b1;
            end
            ifscg_pkg::OP_STEP: begin
              ctl.r_load = 1'b1;
              k_nxt      = '0;
              row_nxt    = '0;
              col_nxt    = '0;
            end
            ifscg_pkg::OP_RESTART: begin
              ctl.restart   = 1'b1;
              oc.load       = 1'b1;
              oc.zero_point = 1'b1;
            end
            default: begin
              oc.load = 1'b1;
            end
          endcase
        end
      end
      ifscg_pkg::ST_P0_RD: begin
        ram_raddr = ifscg_pkg::coef_addr('0, ifscg_pkg::SLOT_W'(ifscg_pkg::PROB_SLOT));
      end
      ifscg_pkg::ST_P0_LD: begin
        ctl.sum_init = 1'b1;
      end
      ifscg_pkg::ST_WTEST: begin
        ram_raddr = ifscg_pkg::coef_addr(ifscg_pkg::addr_t'(k_r) + ifscg_pkg::addr_t'(1),
                                         ifscg_pkg::SLOT_W'(ifscg_pkg::PROB_SLOT));
      end
      ifscg_pkg::ST_WADD: begin
        ctl.sum_add = 1'b1;
        k_nxt       = k_r + ifscg_pkg::map_t'(1);
        // look ahead at the probability after the new map
        ram_raddr   = ifscg_pkg::coef_addr(ifscg_pkg::addr_t'(k_r) + ifscg_pkg::addr_t'(2),
                                           ifscg_pkg::SLOT_W'(ifscg_pkg::PROB_SLOT));
      end
      ifscg_pkg::ST_M_RD: begin
        ram_raddr = ifscg_pkg::coef_addr(ifscg_pkg::addr_t'(k_r), mat_slot);
      end
      ifscg_pkg::ST_M_MUL: begin
        if (col_r == 2'(ifscg_pkg::OFFSET_COL)) begin
          ctl.row_end = 1'b1;
          row_nxt     = row_r + 2'd1;
          col_nxt     = '0;
        end else begin
          ctl.prod_load = 1'b1;
        end
      end
      ifscg_pkg::ST_M_ACC: begin
        ctl.acc_add = 1'b1;
        col_nxt     = col_r + 2'd1;
      end
      ifscg_pkg::ST_DONE: begin
        oc.load   = out_free;
        oc.chosen = ifscg_pkg::MAP_IN_W'(k_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ifscg_pkg::ST_CLEAR;
      clr_r   <= '0;
      k_r     <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ifs_chaos_game_point_engine_unit.sv
// Top level of the 3D IFS chaos-game point engine
//
//   channel  direction  handshake           beat carries
//   in_      input      in_valid/in_stall   op, map_index, coef_slot, coef_value, random_value
//   out_     output     out_valid/out_stall point_x, point_y, point_z, chosen_map
//
// For load, restart and unused op beats the result is registered at acceptance.
// A step beat runs the selection walk over the maps and then the affine evaluation; its pace
// is set by the coefficient RAM's single read port (one read a cycle) and the one shared
// 32x32 multiplier, used nine times.
// After reset a clearing pass writes zero to all 416 table words, in_stall high.
// A stalled result holds in the output register; a new beat is taken once it leaves.
`default_nettype none

module ifs_chaos_game_point_engine_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [1:0]                     in_op,
  input  wire logic        [ifscg_pkg::MAP_IN_W-1:0] in_map_index,
  input  wire logic        [ifscg_pkg::SLOT_W-1:0]   in_coef_slot,
  input  wire logic signed [ifscg_pkg::WORD_W-1:0]   in_coef_value,
  input  wire logic        [ifscg_pkg::RAND_W-1:0]   in_random_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [ifscg_pkg::WORD_W-1:0]   out_point_x,
  output logic signed      [ifscg_pkg::WORD_W-1:0]   out_point_y,
  output logic signed      [ifscg_pkg::WORD_W-1:0]   out_point_z,
  output logic             [ifscg_pkg::MAP_IN_W-1:0] out_chosen_map
);

  ifscg_pkg::dp_ctl_t  ctl;
  ifscg_pkg::dp_sts_t  sts;
  ifscg_pkg::out_ctl_t oc;
  ifscg_pkg::addr_t    ram_waddr, ram_raddr;
  logic                ram_we, out_free;
  logic [ifscg_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
  logic signed [ifscg_pkg::WORD_W-1:0] cur_x, cur_y, cur_z;

  logic                                  out_valid_r;
  logic signed [ifscg_pkg::WORD_W-1:0]   out_x_r, out_y_r, out_z_r;
  logic        [ifscg_pkg::MAP_IN_W-1:0] out_map_r;

  assign out_free = !out_valid_r || !out_stall;

  ifscg_ram #(
    .WIDTH (ifscg_pkg::WORD_W),
    .DEPTH (ifscg_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ifscg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_map_index  (in_map_index),
    .in_coef_slot  (in_coef_slot),
    .in_coef_value (in_coef_value),
    .out_free      (out_free),
    .sts           (sts),
    .ctl           (ctl),
    .oc            (oc),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr)
  );

  ifscg_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_random_value (in_random_value),
    .ctl             (ctl),
    .rd_data         (ram_rdata),
    .sts             (sts),
    .cur_x           (cur_x),
    .cur_y           (cur_y),
    .cur_z           (cur_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (oc.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (oc.load) begin
      out_x_r   <= oc.zero_point ? '0 : cur_x;
      out_y_r   <= oc.zero_point ? '0 : cur_y;
      out_z_r   <= oc.zero_point ? '0 : cur_z;
      out_map_r <= oc.chosen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_point_z    = out_z_r;
  assign out_chosen_map = out_map_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ifscg_checker.sv
// Port-level checker for the IFS point engine, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module ifscg_checker (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_valid,
  input wire logic                                  in_stall,
  input wire logic        [1:0]                     in_op,
  input wire logic        [ifscg_pkg::MAP_IN_W-1:0] in_map_index,
  input wire logic        [ifscg_pkg::SLOT_W-1:0]   in_coef_slot,
  input wire logic signed [ifscg_pkg::WORD_W-1:0]   in_coef_value,
  input wire logic        [ifscg_pkg::RAND_W-1:0]   in_random_value,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic signed [ifscg_pkg::WORD_W-1:0]   out_point_x,
  input wire logic signed [ifscg_pkg::WORD_W-1:0]   out_point_y,
  input wire logic signed [ifscg_pkg::WORD_W-1:0]   out_point_z,
  input wire logic        [ifscg_pkg::MAP_IN_W-1:0] out_chosen_map
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  `IFSCG_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_point_x) && $stable(out_point_y) && $stable(out_point_z) && $stable(out_chosen_map),
    "stalled result beat changed")

  `IFSCG_ASSERT_NXT(a_restart_zero, in_acc && in_op == ifscg_pkg::OP_RESTART,
    out_valid && out_point_x == '0 && out_point_y == '0 && out_point_z == '0 && out_chosen_map == '0,
    "restart did not return the origin")

  `IFSCG_ASSERT_NXT(a_load_result, in_acc && in_op == ifscg_pkg::OP_LOAD,
    out_valid && out_chosen_map == '0,
    "load beat did not return its result at once")

  `IFSCG_ASSERT_NXT(a_step_busy, in_acc && in_op == ifscg_pkg::OP_STEP,
    in_stall,
    "input taken again while a step is running")

  // in_map_index, in_coef_slot, in_coef_value and in_random_value are only checked for unknown bits
  logic unused_ok;
  assign unused_ok = ^{in_map_index, in_coef_slot, in_coef_value, in_random_value};

  `IFSCG_ASSERT_IMP(a_known_fields, in_acc, unused_ok == 1'b0 || unused_ok == 1'b1,
    "input beat carries unknown bits")

endmodule

bind ifs_chaos_game_point_engine_unit ifscg_checker u_ifscg_checker (.*);

`default_nettype wire
